// File: rtl/ale_pkg.sv
`default_nettype none
package ale_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;
  localparam int RES_W    = 40;

  typedef enum logic [4:0] {
    OP_CLEAR         = 5'd0,
    OP_APPEND        = 5'd1,
    OP_INSERT        = 5'd2,
    OP_DELETE        = 5'd3,
    OP_GET           = 5'd4,
    OP_SET           = 5'd5,
    OP_LSEARCH       = 5'd6,
    OP_BSEARCH       = 5'd7,
    OP_MAX           = 5'd8,
    OP_MIN           = 5'd9,
    OP_SUM           = 5'd10,
    OP_SORTED        = 5'd11,
    OP_REVERSE       = 5'd12,
    OP_LSHIFT        = 5'd13,
    OP_RSHIFT        = 5'd14,
    OP_LROT          = 5'd15,
    OP_RROT          = 5'd16,
    OP_SORTED_INSERT = 5'd17,
    OP_PARTITION     = 5'd18
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADIDX   = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_FINAL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [4:0]               opcode;
    logic [CNT_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
  } request_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result_value;
    logic [IDX_W-1:0]        found_index;
    logic                    sorted_flag;
    logic [CNT_W-1:0]        entry_count;
    logic [2:0]              status;
  } result_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic                     rot;
    logic                     shr;
    logic                     shl;
    logic [CNT_W-1:0]         lo;
    logic [CNT_W-1:0]         hi;
    logic                     wa_en;
    logic [IDX_W-1:0]         wa;
    logic signed [DATA_W-1:0] wa_val;
    logic                     wb_en;
    logic [IDX_W-1:0]         wb;
    logic signed [DATA_W-1:0] wb_val;
  } cell_cmd_t;

endpackage
`default_nettype wire

// File: rtl/ale_cell.sv
`default_nettype none
module ale_cell (
  input  wire logic                                  clk,
  input  wire logic [ale_pkg::IDX_W-1:0]             idx,
  input  wire ale_pkg::cell_cmd_t                    cmd,
  input  wire logic signed [ale_pkg::DATA_W-1:0]     left,
  input  wire logic signed [ale_pkg::DATA_W-1:0]     right,
  output logic signed [ale_pkg::DATA_W-1:0]          value
);

  logic [ale_pkg::CNT_W-1:0] pos;

  assign pos = {1'b0, idx};

  // Direct writes win over the range shifts.
  always_ff @(posedge clk) begin
    priority if (cmd.rot) begin
      value <= right;
    end else if (cmd.wa_en && idx == cmd.wa) begin
      value <= cmd.wa_val;
    end else if (cmd.wb_en && idx == cmd.wb) begin
      value <= cmd.wb_val;
    end else if (cmd.shr && pos > cmd.lo && pos <= cmd.hi) begin
      value <= left;
    end else if (cmd.shl && pos >= cmd.lo && pos < cmd.hi) begin
      value <= right;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ale_seq.sv
`default_nettype none
module ale_seq (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire ale_pkg::request_t                 request,
  input  wire logic signed [ale_pkg::DATA_W-1:0] head,
  output ale_pkg::cell_cmd_t                     cmd,
  output logic                                   done,
  output ale_pkg::result_t                       result
);

  localparam logic [ale_pkg::IDX_W-1:0] LAST = ale_pkg::IDX_W'(ale_pkg::CAPACITY - 1);
  localparam logic [ale_pkg::CNT_W-1:0] CAP  = ale_pkg::CNT_W'(ale_pkg::CAPACITY);

  ale_pkg::state_t state, state_next;

  logic [ale_pkg::IDX_W-1:0]         r;
  logic [4:0]                        op;
  logic [ale_pkg::CNT_W-1:0]         pos;
  logic signed [ale_pkg::DATA_W-1:0] item;
  logic [ale_pkg::CNT_W-1:0]         count, count_next;
  logic [2:0]                        st, st_next;
  logic [ale_pkg::IDX_W-1:0]         pa, pa_next, pb, pb_next;
  logic [ale_pkg::CNT_W-1:0]         lo, lo_next, hp, hp_next;
  logic [ale_pkg::IDX_W-1:0]         fidx, fidx_next;
  logic                              hit;
  logic signed [ale_pkg::DATA_W-1:0] va, vb, mx, mn, prev;
  logic signed [ale_pkg::RES_W-1:0]  sum;
  logic                              sorted;
  logic                              afound, bfound;
  logic [ale_pkg::IDX_W-1:0]         anew, bnew;
  logic [ale_pkg::CNT_W-1:0]         kins;
  logic                              iterate;
  logic                              pass_start;
  logic                              scanning;
  logic                              valid;
  logic [ale_pkg::CNT_W:0]           mid_sum;
  logic [ale_pkg::CNT_W-1:0]         mid_next;
  logic [ale_pkg::CNT_W-1:0]         start_mid;
  logic signed [ale_pkg::RES_W-1:0]  rv;

  assign busy     = (state != ale_pkg::S_IDLE);
  assign scanning = (state == ale_pkg::S_SCAN) || (state == ale_pkg::S_FINAL);
  assign valid    = ({1'b0, r} < count);
  assign pass_start = (state == ale_pkg::S_IDLE && start) || (state == ale_pkg::S_APPLY);
  assign start_mid = (count == '0) ? '0 : ale_pkg::CNT_W'((count - 1'b1) >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ale_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    count_next = count;
    st_next    = st;
    pa_next    = pa;
    pb_next    = pb;
    lo_next    = lo;
    hp_next    = hp;
    fidx_next  = fidx;
    iterate    = 1'b0;
    mid_sum    = '0;
    mid_next   = '0;
    unique case (state)
      ale_pkg::S_IDLE: begin
        if (start) begin
          state_next = ale_pkg::S_SCAN;
        end
      end
      ale_pkg::S_SCAN: begin
        cmd.rot = 1'b1;
        if (r == LAST) begin
          state_next = ale_pkg::S_APPLY;
        end
      end
      ale_pkg::S_FINAL: begin
        cmd.rot = 1'b1;
        if (r == LAST) begin
          state_next = ale_pkg::S_DONE;
        end
      end
      ale_pkg::S_DONE: begin
        state_next = ale_pkg::S_IDLE;
      end
      ale_pkg::S_APPLY: begin
        st_next = ale_pkg::ST_OK;
        unique case (op)
          ale_pkg::OP_CLEAR: begin
            count_next = '0;
          end
          ale_pkg::OP_APPEND: begin
            if (count >= CAP) begin
              st_next = ale_pkg::ST_FULL;
            end else begin
              cmd.wa_en  = 1'b1;
              cmd.wa     = count[ale_pkg::IDX_W-1:0];
              cmd.wa_val = item;
              count_next = count + 1'b1;
            end
          end
          ale_pkg::OP_INSERT: begin
            if (pos > count) begin
              st_next = ale_pkg::ST_BADIDX;
            end else if (count >= CAP) begin
              st_next = ale_pkg::ST_FULL;
            end else begin
              cmd.shr    = 1'b1;
              cmd.lo     = pos;
              cmd.hi     = count;
              cmd.wa_en  = 1'b1;
              cmd.wa     = pos[ale_pkg::IDX_W-1:0];
              cmd.wa_val = item;
              count_next = count + 1'b1;
            end
          end
          ale_pkg::OP_DELETE: begin
            if (count == '0) begin
              st_next = ale_pkg::ST_EMPTY;
            end else if (pos >= count) begin
              st_next = ale_pkg::ST_BADIDX;
            end else begin
              cmd.shl    = 1'b1;
              cmd.lo     = pos;
              cmd.hi     = count - 1'b1;
              count_next = count - 1'b1;
            end
          end
          ale_pkg::OP_GET: begin
            if (pos >= count) begin
              st_next = ale_pkg::ST_BADIDX;
            end
          end
          ale_pkg::OP_SET: begin
            if (pos >= count) begin
              st_next = ale_pkg::ST_BADIDX;
            end else begin
              cmd.wa_en  = 1'b1;
              cmd.wa     = pos[ale_pkg::IDX_W-1:0];
              cmd.wa_val = item;
            end
          end
          ale_pkg::OP_LSEARCH: begin
            if (hit) begin
              // The hit equals the key, so entry 0 simply takes the key.
              cmd.wa_en  = 1'b1;
              cmd.wa     = fidx;
              cmd.wa_val = va;
              cmd.wb_en  = 1'b1;
              cmd.wb     = '0;
              cmd.wb_val = item;
            end else begin
              st_next = ale_pkg::ST_NOTFOUND;
            end
          end
          ale_pkg::OP_BSEARCH: begin
            if (lo < hp) begin
              if (va == item) begin
                fidx_next = pa;
              end else begin
                if (va > item) begin
                  hp_next = {1'b0, pa};
                end else begin
                  lo_next = {1'b0, pa} + 1'b1;
                end
                mid_sum  = {1'b0, lo_next} + {1'b0, hp_next} - 1'b1;
                mid_next = mid_sum[ale_pkg::CNT_W:1];
                if (lo_next < hp_next) begin
                  iterate = 1'b1;
                  pa_next = mid_next[ale_pkg::IDX_W-1:0];
                end else begin
                  st_next = ale_pkg::ST_NOTFOUND;
                end
              end
            end else begin
              st_next = ale_pkg::ST_NOTFOUND;
            end
          end
          ale_pkg::OP_MAX, ale_pkg::OP_MIN: begin
            if (count == '0) begin
              st_next = ale_pkg::ST_EMPTY;
            end
          end
          ale_pkg::OP_REVERSE: begin
            if (pa < pb) begin
              cmd.wa_en  = 1'b1;
              cmd.wa     = pa;
              cmd.wa_val = vb;
              cmd.wb_en  = 1'b1;
              cmd.wb     = pb;
              cmd.wb_val = va;
              pa_next    = pa + 1'b1;
              pb_next    = pb - 1'b1;
              iterate    = (pa_next < pb_next);
            end
          end
          ale_pkg::OP_LSHIFT, ale_pkg::OP_LROT: begin
            if (count == '0) begin
              st_next = ale_pkg::ST_EMPTY;
            end else begin
              cmd.shl    = 1'b1;
              cmd.lo     = '0;
              cmd.hi     = count - 1'b1;
              cmd.wa_en  = 1'b1;
              cmd.wa     = pb;
              cmd.wa_val = (op == ale_pkg::OP_LROT) ? va : '0;
            end
          end
          ale_pkg::OP_RSHIFT, ale_pkg::OP_RROT: begin
            if (count == '0) begin
              st_next = ale_pkg::ST_EMPTY;
            end else begin
              cmd.shr    = 1'b1;
              cmd.lo     = '0;
              cmd.hi     = count - 1'b1;
              cmd.wa_en  = 1'b1;
              cmd.wa     = '0;
              cmd.wa_val = (op == ale_pkg::OP_RROT) ? vb : '0;
            end
          end
          ale_pkg::OP_SORTED_INSERT: begin
            if (count >= CAP) begin
              st_next = ale_pkg::ST_FULL;
            end else begin
              cmd.shr    = 1'b1;
              cmd.lo     = kins;
              cmd.hi     = count;
              cmd.wa_en  = 1'b1;
              cmd.wa     = kins[ale_pkg::IDX_W-1:0];
              cmd.wa_val = item;
              count_next = count + 1'b1;
            end
          end
          ale_pkg::OP_PARTITION: begin
            if (afound && bfound) begin
              cmd.wa_en  = 1'b1;
              cmd.wa     = anew;
              cmd.wa_val = vb;
              cmd.wb_en  = 1'b1;
              cmd.wb     = bnew;
              cmd.wb_val = va;
              pa_next    = anew;
              pb_next    = bnew;
              iterate    = 1'b1;
            end
          end
          default: begin
          end
        endcase
        state_next = iterate ? ale_pkg::S_SCAN : ale_pkg::S_FINAL;
      end
      default: begin
        state_next = ale_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    rv = '0;
    if (st == ale_pkg::ST_OK) begin
      unique case (op)
        ale_pkg::OP_GET: rv = ale_pkg::RES_W'(va);
        ale_pkg::OP_MAX: rv = ale_pkg::RES_W'(mx);
        ale_pkg::OP_MIN: rv = ale_pkg::RES_W'(mn);
        ale_pkg::OP_SUM: rv = sum;
        default:         rv = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
      r     <= '0;
    end else begin
      done <= (state == ale_pkg::S_DONE);
      if (state == ale_pkg::S_APPLY) begin
        count <= count_next;
      end
      if (pass_start) begin
        r <= '0;
      end else if (scanning) begin
        r <= r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ale_pkg::S_IDLE && start) begin
      op   <= request.opcode;
      pos  <= request.position;
      item <= request.item_value;
      fidx <= '0;
      hit  <= 1'b0;
      st   <= ale_pkg::ST_OK;
      lo   <= '0;
      hp   <= count;
      pb   <= (count == '0) ? '0 : ale_pkg::IDX_W'(count - 1'b1);
      if (request.opcode == ale_pkg::OP_GET) begin
        pa <= request.position[ale_pkg::IDX_W-1:0];
      end else if (request.opcode == ale_pkg::OP_BSEARCH) begin
        pa <= start_mid[ale_pkg::IDX_W-1:0];
      end else begin
        pa <= '0;
      end
    end else if (state == ale_pkg::S_APPLY) begin
      st   <= st_next;
      fidx <= fidx_next;
      pa   <= pa_next;
      pb   <= pb_next;
      lo   <= lo_next;
      hp   <= hp_next;
    end

    if (pass_start) begin
      sum    <= '0;
      sorted <= 1'b1;
      afound <= 1'b0;
      bfound <= 1'b0;
      kins   <= '0;
    end else if (scanning) begin
      prev <= head;
      if (valid) begin
        sum <= sum + {{(ale_pkg::RES_W - ale_pkg::DATA_W){head[ale_pkg::DATA_W-1]}}, head};
        if (r == '0) begin
          mx <= head;
          mn <= head;
        end else begin
          if (head > mx) mx <= head;
          if (head < mn) mn <= head;
          if (prev > head) sorted <= 1'b0;
        end
        if (head <= item) kins <= {1'b0, r} + 1'b1;
        if (state == ale_pkg::S_SCAN && op == ale_pkg::OP_LSEARCH && !hit && head == item) begin
          hit  <= 1'b1;
          fidx <= r;
        end
      end
      if (op == ale_pkg::OP_PARTITION) begin
        // One pass finds the next nonnegative from the left and the last
        // negative after it, up to the right bound.
        if (!afound && r >= pa && r < pb && head >= 0) begin
          afound <= 1'b1;
          anew   <= r;
          va     <= head;
        end else if (afound && r <= pb && head < 0) begin
          bfound <= 1'b1;
          bnew   <= r;
          vb     <= head;
        end
      end else begin
        if (r == pa) va <= head;
        if (r == pb) vb <= head;
      end
    end

    if (state == ale_pkg::S_DONE) begin
      result.result_value <= rv;
      result.found_index  <= fidx;
      result.sorted_flag  <= sorted;
      result.entry_count  <= count;
      result.status       <= st;
    end
  end

endmodule
`default_nettype wire

// File: rtl/array_list_engine.sv
`default_nettype none
// List engine: keeps up to 64 signed 32-bit entries and a count, and serves
// one request at a time (clear, append, insert, delete, get, set, searches,
// max, min, sum, order check, reverse, shifts, rotates, sorted insert and
// partition).
// A request is taken on a clock edge where start is high and busy is low.
// The entries sit in a ring of cells that rotates one place per cycle while
// a pass runs, so the sequencer sees every entry at the head of the ring
// during a pass. A request takes a scan pass to gather values, an update of
// the ring, and a final pass to rebuild the order flag; the result strobe
// done is registered from the done state that follows. Binary search adds a
// pass and ring update per extra probe (up to 6), reverse one per swap
// beyond the first, and partition one per swap.
// The result stands on result for the single cycle that done is high; the
// receiver cannot stall it, and the next request may be taken that cycle.
// Reset empties the list and returns the sequencer to idle; the entry cells
// themselves are not cleared.
module array_list_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire ale_pkg::request_t request,
  output logic                   done,
  output ale_pkg::result_t       result
);

  logic signed [ale_pkg::DATA_W-1:0] cell_val [ale_pkg::CAPACITY];
  ale_pkg::cell_cmd_t                cmd;

  ale_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .head    (cell_val[0]),
    .cmd     (cmd),
    .done    (done),
    .result  (result)
  );

  for (genvar i = 0; i < ale_pkg::CAPACITY; i++) begin : g_cell
    ale_cell u_cell (
      .clk   (clk),
      .idx   (ale_pkg::IDX_W'(i)),
      .cmd   (cmd),
      .left  (cell_val[(i + ale_pkg::CAPACITY - 1) % ale_pkg::CAPACITY]),
      .right (cell_val[(i + 1) % ale_pkg::CAPACITY]),
      .value (cell_val[i])
    );
  end

endmodule
`default_nettype wire

// File: test/array_list_checker.sv
`default_nettype none
module array_list_checker (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire ale_pkg::request_t request,
  input  wire logic              done,
  input  wire ale_pkg::result_t  result,
  output int                     fails,
  output int                     waiting,
  output int                     list_len
);

  localparam longint SUM_HI = 64'sd549755813887;
  localparam longint SUM_LO = -64'sd549755813888;

  logic signed [ale_pkg::DATA_W-1:0] entries [ale_pkg::CAPACITY];
  int                                count;
  ale_pkg::result_t                  expected_results [$];

  initial fails = 0;
  assign waiting  = expected_results.size();
  assign list_len = count;

  task automatic swap_entries(input int a, input int b);
    logic signed [ale_pkg::DATA_W-1:0] t;
    t = entries[a];
    entries[a] = entries[b];
    entries[b] = t;
  endtask

  // Applies one request to the shadow list and returns the result it should give.
  task automatic apply_request(input ale_pkg::request_t r, output ale_pkg::result_t x);
    int n, p, i, lo, hi, m, a, b;
    longint acc;
    logic signed [ale_pkg::DATA_W-1:0] first, last;
    logic [2:0] st;
    logic [ale_pkg::IDX_W-1:0] hit;
    logic ok_order;
    n = count;
    p = r.position;
    acc = 0;
    st = ale_pkg::ST_OK;
    hit = '0;
    case (r.opcode)
      ale_pkg::OP_CLEAR: count = 0;
      ale_pkg::OP_APPEND: begin
        if (n >= ale_pkg::CAPACITY) st = ale_pkg::ST_FULL;
        else begin
          entries[n] = r.item_value;
          count = n + 1;
        end
      end
      ale_pkg::OP_INSERT: begin
        if (p > n) st = ale_pkg::ST_BADIDX;
        else if (n >= ale_pkg::CAPACITY) st = ale_pkg::ST_FULL;
        else begin
          for (i = n; i > p; i--) entries[i] = entries[i-1];
          entries[p] = r.item_value;
          count = n + 1;
        end
      end
      ale_pkg::OP_DELETE: begin
        if (n == 0) st = ale_pkg::ST_EMPTY;
        else if (p >= n) st = ale_pkg::ST_BADIDX;
        else begin
          for (i = p; i + 1 < n; i++) entries[i] = entries[i+1];
          count = n - 1;
        end
      end
      ale_pkg::OP_GET: begin
        if (p >= n) st = ale_pkg::ST_BADIDX;
        else acc = entries[p];
      end
      ale_pkg::OP_SET: begin
        if (p >= n) st = ale_pkg::ST_BADIDX;
        else entries[p] = r.item_value;
      end
      ale_pkg::OP_LSEARCH: begin
        st = ale_pkg::ST_NOTFOUND;
        for (i = 0; i < n; i++) begin
          if (entries[i] == r.item_value) begin
            hit = ale_pkg::IDX_W'(i);
            swap_entries(i, 0);
            st = ale_pkg::ST_OK;
            break;
          end
        end
      end
      ale_pkg::OP_BSEARCH: begin
        lo = 0;
        hi = n - 1;
        st = ale_pkg::ST_NOTFOUND;
        while (lo <= hi) begin
          m = (lo + hi) / 2;
          if (entries[m] == r.item_value) begin
            hit = ale_pkg::IDX_W'(m);
            st = ale_pkg::ST_OK;
            break;
          end
          if (entries[m] > r.item_value) hi = m - 1;
          else lo = m + 1;
        end
      end
      ale_pkg::OP_MAX, ale_pkg::OP_MIN: begin
        if (n == 0) st = ale_pkg::ST_EMPTY;
        else begin
          acc = entries[0];
          for (i = 1; i < n; i++) begin
            if (r.opcode == ale_pkg::OP_MAX ? entries[i] > acc : entries[i] < acc)
              acc = entries[i];
          end
        end
      end
      ale_pkg::OP_SUM: begin
        for (i = 0; i < n; i++) acc += entries[i];
        if (acc > SUM_HI) acc = SUM_HI;
        if (acc < SUM_LO) acc = SUM_LO;
      end
      ale_pkg::OP_REVERSE: begin
        a = 0;
        b = n - 1;
        while (a < b) begin
          swap_entries(a, b);
          a++;
          b--;
        end
      end
      ale_pkg::OP_LSHIFT, ale_pkg::OP_RSHIFT, ale_pkg::OP_LROT, ale_pkg::OP_RROT: begin
        if (n == 0) st = ale_pkg::ST_EMPTY;
        else begin
          first = entries[0];
          last = entries[n-1];
          if (r.opcode == ale_pkg::OP_LSHIFT || r.opcode == ale_pkg::OP_LROT) begin
            for (i = 0; i + 1 < n; i++) entries[i] = entries[i+1];
            entries[n-1] = (r.opcode == ale_pkg::OP_LROT) ? first : '0;
          end else begin
            for (i = n - 1; i > 0; i--) entries[i] = entries[i-1];
            entries[0] = (r.opcode == ale_pkg::OP_RROT) ? last : '0;
          end
        end
      end
      ale_pkg::OP_SORTED_INSERT: begin
        if (n >= ale_pkg::CAPACITY) st = ale_pkg::ST_FULL;
        else begin
          i = n;
          while (i > 0 && entries[i-1] > r.item_value) begin
            entries[i] = entries[i-1];
            i--;
          end
          entries[i] = r.item_value;
          count = n + 1;
        end
      end
      ale_pkg::OP_PARTITION: begin
        a = 0;
        b = n - 1;
        while (a < b) begin
          while (a < b && entries[a] < 0) a++;
          while (a < b && entries[b] >= 0) b--;
          if (a < b) swap_entries(a, b);
        end
      end
      default: ;
    endcase
    ok_order = 1'b1;
    for (i = 1; i < count; i++) if (entries[i-1] > entries[i]) ok_order = 1'b0;
    x.result_value = acc[ale_pkg::RES_W-1:0];
    x.found_index  = hit;
    x.sorted_flag  = ok_order;
    x.entry_count  = count[ale_pkg::CNT_W-1:0];
    x.status       = st;
  endtask

  always @(posedge clk) begin
    ale_pkg::result_t want, got;
    if (rst) begin
      count = 0;
      expected_results.delete();
    end else begin
      if (done) begin
        got = result;
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request pending: %p", $time, got);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (got.result_value !== want.result_value) begin
            $display("%0t: result_value expected %0d got %0d", $time,
                     want.result_value, got.result_value);
            fails++;
          end
          if (got.found_index !== want.found_index) begin
            $display("%0t: found_index expected %0d got %0d", $time,
                     want.found_index, got.found_index);
            fails++;
          end
          if (got.sorted_flag !== want.sorted_flag) begin
            $display("%0t: sorted_flag expected %0d got %0d", $time,
                     want.sorted_flag, got.sorted_flag);
            fails++;
          end
          if (got.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d got %0d", $time,
                     want.entry_count, got.entry_count);
            fails++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        apply_request(request, want);
        expected_results.push_back(want);
      end
    end
  end
endmodule
`default_nettype wire

// File: test/array_list_engine_tb.sv
`default_nettype none
module array_list_engine_tb;

  localparam int IDLE_LIMIT = 20000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  ale_pkg::request_t request = '0;
  logic              busy, done;
  ale_pkg::result_t  result;
  int                fails, waiting, list_len;
  int                idle_cycles = 0;
  int                burst_left = 0;

  initial forever #1 clk = ~clk;

  array_list_engine dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  array_list_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .fails(fails), .waiting(waiting), .list_len(list_len)
  );

  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Holds the request until it is taken; start stays high for a following request.
  task automatic issue(input ale_pkg::op_t op, input int pos, input logic signed [31:0] val);
    request <= '{opcode: op, position: pos[6:0], item_value: val};
    start <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic pace();
    if (burst_left > 0) burst_left--;
    else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request();
    ale_pkg::op_t op;
    int  pos;
    int  r;
    r = $urandom_range(0, 99);
    if (r < 22) op = (list_len > 24) ? ale_pkg::OP_DELETE : ale_pkg::OP_APPEND;
    else if (r < 32) op = (list_len > 24) ? ale_pkg::OP_DELETE : ale_pkg::OP_SORTED_INSERT;
    else if (r < 36) op = ale_pkg::op_t'(5'($urandom_range(19, 31)));
    else if (r < 38) op = ale_pkg::OP_CLEAR;
    else op = ale_pkg::op_t'(5'($urandom_range(2, 18)));
    if ($urandom_range(0, 7) == 0) pos = $urandom_range(0, 127);
    else pos = $urandom_range(0, list_len + 1);
    issue(op, pos, pick_value());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty-list corner cases first, then a small list through a mix of the operations.
    issue(ale_pkg::OP_MAX, 0, 0);
    issue(ale_pkg::OP_MIN, 0, 0);
    issue(ale_pkg::OP_SUM, 0, 0);
    issue(ale_pkg::OP_LSHIFT, 0, 0);
    issue(ale_pkg::OP_DELETE, 0, 0);
    issue(ale_pkg::OP_GET, 0, 0);
    issue(ale_pkg::OP_LSEARCH, 0, 5);
    issue(ale_pkg::OP_BSEARCH, 0, 5);
    issue(ale_pkg::OP_REVERSE, 0, 0);
    issue(ale_pkg::OP_PARTITION, 0, 0);
    issue(ale_pkg::op_t'(5'd31), 127, -1);
    issue(ale_pkg::OP_APPEND, 0, 32'sh8000_0000);
    issue(ale_pkg::OP_APPEND, 0, 32'sh7fff_ffff);
    issue(ale_pkg::OP_INSERT, 5, 1);
    issue(ale_pkg::OP_INSERT, 1, -1);
    issue(ale_pkg::OP_GET, 2, 0);
    issue(ale_pkg::OP_SET, 100, 3);
    issue(ale_pkg::OP_SET, 1, 3);
    issue(ale_pkg::OP_LSEARCH, 0, 32'sh7fff_ffff);
    issue(ale_pkg::OP_SORTED_INSERT, 0, 0);
    issue(ale_pkg::OP_BSEARCH, 0, 0);
    issue(ale_pkg::OP_PARTITION, 0, 0);
    issue(ale_pkg::OP_LROT, 0, 0);
    issue(ale_pkg::OP_RROT, 0, 0);
    issue(ale_pkg::OP_RSHIFT, 0, 0);
    issue(ale_pkg::OP_SUM, 0, 0);
    start <= 1'b0;
    // Hold off until the block has drained everything outstanding.
    while (waiting != 0) @(posedge clk);

    for (int k = 0; k < 500; k++) begin
      if (k % 300 == 150) begin
        // Fill to capacity with large values so the sum runs far past the entry width and full shows.
        issue(ale_pkg::OP_CLEAR, 0, 0);
        for (int j = 0; j < 66; j++)
          issue(ale_pkg::OP_APPEND, 0, (j % 2) ? 32'sh7fff_ffff : $urandom);
        issue(ale_pkg::OP_SUM, 0, 0);
        issue(ale_pkg::OP_INSERT, 64, 1);
        issue(ale_pkg::OP_INSERT, 65, 1);
        issue(ale_pkg::OP_SORTED_INSERT, 0, 1);
        issue(ale_pkg::OP_GET, 63, 0);
        issue(ale_pkg::OP_DELETE, 64, 0);
        issue(ale_pkg::OP_PARTITION, 0, 0);
        issue(ale_pkg::OP_CLEAR, 0, 0);
        for (int j = 0; j < 64; j++) issue(ale_pkg::OP_APPEND, 0, 32'sh8000_0000);
        issue(ale_pkg::OP_SUM, 0, 0);
        issue(ale_pkg::OP_CLEAR, 0, 0);
      end
      random_request();
      pace();
    end
    start <= 1'b0;
    while (waiting != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
